@@ hw/rtl/bmp24rgba_pkg.sv @@
// Shared types and constants for the 24-bit bitmap to RGBA stream decoder.
package bmp24rgba_pkg;

	// Default size limits for the decoded image
	localparam int unsigned DEF_MAX_WIDTH  = 4096;
	localparam int unsigned DEF_MAX_HEIGHT = 4096;

	// Header byte positions at which a little-endian word is complete
	localparam logic [31:0] POS_SIG_LAST    = 32'd1;
	localparam logic [31:0] POS_OFFSET_LAST = 32'h0a + 32'd3;
	localparam logic [31:0] POS_WIDTH_LAST  = 32'h12 + 32'd3;
	localparam logic [31:0] POS_HEIGHT_LAST = 32'h16 + 32'd3;
	localparam logic [31:0] HEADER_END      = 32'd26;

	// Signature bytes and the opaque alpha value
	localparam logic [7:0] SIG_B        = 8'h42;
	localparam logic [7:0] SIG_M        = 8'h4d;
	localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

	typedef enum logic [1:0] {
		KIND_PIXEL      = 2'd0,
		KIND_BAD_SIG    = 2'd1,
		KIND_BAD_HEADER = 2'd2
	} result_kind_t;

	// One file byte transaction
	typedef struct packed {
		logic [7:0] file_byte;
		logic       file_start;
	} in_item_t;

	// One decoded result transaction
	typedef struct packed {
		result_kind_t result_kind;
		logic [23:0]  pixel_index;
		logic [7:0]   out_red;
		logic [7:0]   out_green;
		logic [7:0]   out_blue;
		logic [7:0]   out_alpha;
		logic [12:0]  image_width;
		logic [12:0]  image_height;
		logic         last_pixel;
	} result_t;

endpackage

@@ hw/rtl/bmp24rgba_parser.sv @@
// Header parser and pixel assembler that turns one file byte into at most one result.
module bmp24rgba_parser #(
	parameter int unsigned MAX_WIDTH  = bmp24rgba_pkg::DEF_MAX_WIDTH,
	parameter int unsigned MAX_HEIGHT = bmp24rgba_pkg::DEF_MAX_HEIGHT
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  bmp24rgba_pkg::in_item_t item,
	input  logic [23:0]            color_key,
	output logic                   emit,
	output bmp24rgba_pkg::result_t result
);

	localparam int unsigned COL_W = $clog2(MAX_WIDTH + 1);
	localparam int unsigned ROW_W = $clog2(MAX_HEIGHT + 1);

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_SKIP,
		PH_PIXEL,
		PH_IDLE
	} phase_t;

	phase_t             phase_q, phase_cur, phase_d;
	logic [31:0]        pos_q, pos_cur, pos_d;
	logic [31:0]        hword_q, hword_cur, hword_sh, hword_d;
	logic [31:0]        start_q, start_d;
	logic [COL_W-1:0]   width_q, width_d;
	logic [ROW_W-1:0]   height_q, height_d;
	logic [15:0]        pbytes_q, pbytes_d;
	logic [1:0]         bip_q, bip_d;
	logic [COL_W-1:0]   col_q, col_d, col_inc;
	logic [ROW_W-1:0]   row_q, row_d, row_inc;
	logic [1:0]         pad_q, pad_d;
	logic [23:0]        dest_q, dest_d;
	logic               run_pixel;
	logic [23:0]        color;
	logic               keyed;

	// Next-state and result logic for one byte
	always_comb begin
		// A start marker restarts the parse at byte zero of a new file
		pos_cur   = item.file_start ? '0 : pos_q;
		phase_cur = item.file_start ? PH_HEADER : phase_q;
		hword_cur = item.file_start ? '0 : hword_q;
		hword_sh  = {item.file_byte, hword_cur[31:8]};

		pos_d    = (pos_cur == '1) ? pos_cur : pos_cur + 32'd1;
		phase_d  = phase_cur;
		hword_d  = hword_cur;
		start_d  = start_q;
		width_d  = width_q;
		height_d = height_q;
		pbytes_d = pbytes_q;
		bip_d    = bip_q;
		col_d    = col_q;
		row_d    = row_q;
		pad_d    = pad_q;
		dest_d   = dest_q;
		col_inc  = col_q + COL_W'(1);
		row_inc  = row_q + ROW_W'(1);
		color    = {item.file_byte, pbytes_q};
		keyed    = (color == color_key);

		run_pixel = 1'b0;
		emit      = 1'b0;
		result    = '0;

		case (phase_cur)
			PH_HEADER: begin
				hword_d = hword_sh;
				if (pos_cur == bmp24rgba_pkg::POS_SIG_LAST) begin
					if (hword_sh[31:16] != {bmp24rgba_pkg::SIG_M, bmp24rgba_pkg::SIG_B}) begin
						emit               = 1'b1;
						result.result_kind = bmp24rgba_pkg::KIND_BAD_SIG;
						phase_d            = PH_IDLE;
					end
				end else if (pos_cur == bmp24rgba_pkg::POS_OFFSET_LAST) begin
					start_d = hword_sh;
					if (hword_sh < bmp24rgba_pkg::HEADER_END) begin
						emit               = 1'b1;
						result.result_kind = bmp24rgba_pkg::KIND_BAD_HEADER;
						phase_d            = PH_IDLE;
					end
				end else if (pos_cur == bmp24rgba_pkg::POS_WIDTH_LAST) begin
					if (hword_sh == '0 || hword_sh > 32'(MAX_WIDTH)) begin
						emit               = 1'b1;
						result.result_kind = bmp24rgba_pkg::KIND_BAD_HEADER;
						phase_d            = PH_IDLE;
					end else begin
						width_d = hword_sh[COL_W-1:0];
					end
				end else if (pos_cur == bmp24rgba_pkg::POS_HEIGHT_LAST) begin
					if (hword_sh == '0 || hword_sh > 32'(MAX_HEIGHT)) begin
						emit               = 1'b1;
						result.result_kind = bmp24rgba_pkg::KIND_BAD_HEADER;
						phase_d            = PH_IDLE;
					end else begin
						// Rows arrive bottom first, so start at the last row
						height_d = hword_sh[ROW_W-1:0];
						dest_d   = 24'(width_q) * (24'(hword_sh[ROW_W-1:0]) - 24'd1);
						col_d    = '0;
						row_d    = '0;
						bip_d    = '0;
						pad_d    = '0;
						phase_d  = PH_SKIP;
					end
				end
			end
			PH_SKIP: begin
				if (pos_cur >= start_q) begin
					phase_d   = PH_PIXEL;
					run_pixel = 1'b1;
				end
			end
			PH_PIXEL: begin
				run_pixel = 1'b1;
			end
			default: begin
			end
		endcase

		// Padding skip, pixel assembly and destination stepping
		if (run_pixel) begin
			if (pad_q != 2'd0) begin
				pad_d = pad_q - 2'd1;
			end else if (bip_q == 2'd0) begin
				pbytes_d = {pbytes_q[15:8], item.file_byte};
				bip_d    = 2'd1;
			end else if (bip_q == 2'd1) begin
				pbytes_d = {item.file_byte, pbytes_q[7:0]};
				bip_d    = 2'd2;
			end else begin
				bip_d               = 2'd0;
				emit                = 1'b1;
				result.result_kind  = bmp24rgba_pkg::KIND_PIXEL;
				result.pixel_index  = dest_q;
				result.out_red      = keyed ? 8'd0 : color[23:16];
				result.out_green    = keyed ? 8'd0 : color[15:8];
				result.out_blue     = keyed ? 8'd0 : color[7:0];
				result.out_alpha    = keyed ? 8'd0 : bmp24rgba_pkg::ALPHA_OPAQUE;
				result.image_width  = 13'(width_q);
				result.image_height = 13'(height_q);
				if (col_inc >= width_q) begin
					// End of a row: padding equals the width modulo four
					col_d = '0;
					row_d = row_inc;
					pad_d = 2'(width_q);
					if (row_inc >= height_q) begin
						result.last_pixel = 1'b1;
						phase_d           = PH_IDLE;
					end else begin
						dest_d = dest_q + 24'd1 - (24'(width_q) << 1);
					end
				end else begin
					col_d  = col_inc;
					dest_d = dest_q + 24'd1;
				end
			end
		end
	end

	// Parse state, advanced once per processed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			pos_q    <= '0;
			hword_q  <= '0;
			start_q  <= '0;
			width_q  <= '0;
			height_q <= '0;
			pbytes_q <= '0;
			bip_q    <= '0;
			col_q    <= '0;
			row_q    <= '0;
			pad_q    <= '0;
			dest_q   <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			pos_q    <= pos_d;
			hword_q  <= hword_d;
			start_q  <= start_d;
			width_q  <= width_d;
			height_q <= height_d;
			pbytes_q <= pbytes_d;
			bip_q    <= bip_d;
			col_q    <= col_d;
			row_q    <= row_d;
			pad_q    <= pad_d;
			dest_q   <= dest_d;
		end
	end

endmodule

@@ hw/rtl/bmp24_stream_to_rgba.sv @@
// 24-bit bitmap byte stream to RGBA pixel decoder with colour key.
// After its last byte is accepted, a result passes the input register,
// then the result register.
// Throughput: one file byte per cycle, held back only while the result
// register is full and stalled. Reset clears the parse to the start of a
// new file and sets the colour key to zero.
module bmp24_stream_to_rgba #(
	parameter int unsigned MAX_WIDTH  = bmp24rgba_pkg::DEF_MAX_WIDTH,
	parameter int unsigned MAX_HEIGHT = bmp24rgba_pkg::DEF_MAX_HEIGHT
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_write_en,
	input  logic [23:0]             cfg_write_data,
	input  logic                    byte_valid,
	output logic                    byte_stall,
	input  bmp24rgba_pkg::in_item_t byte_data,
	output logic                    result_valid,
	input  logic                    result_stall,
	output bmp24rgba_pkg::result_t  result_data
);

	logic                    valid_s1;
	bmp24rgba_pkg::in_item_t item_s1;
	logic                    valid_s2;
	bmp24rgba_pkg::result_t  result_s2;
	logic [23:0]             color_key_q;
	logic                    take_s2;
	logic                    step;
	logic                    emit;
	bmp24rgba_pkg::result_t  result_c;

	// Flow control: the result register drains or is empty
	assign take_s2    = !valid_s2 || !result_stall;
	assign step       = valid_s1 && take_s2;
	assign byte_stall = valid_s1 && !take_s2;

	bmp24rgba_parser #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.item      (item_s1),
		.color_key (color_key_q),
		.emit      (emit),
		.result    (result_c)
	);

	// Control state: stage valid flags and the colour key register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			color_key_q <= '0;
		end else begin
			if (!byte_stall) begin
				valid_s1 <= byte_valid;
			end
			if (take_s2) begin
				valid_s2 <= step && emit;
			end
			if (cfg_write_en) begin
				color_key_q <= cfg_write_data;
			end
		end
	end

	// Payload registers for the input and result transactions
	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			item_s1 <= byte_data;
		end
		if (step && emit) begin
			result_s2 <= result_c;
		end
	end

	assign result_valid = valid_s2;
	assign result_data  = result_s2;

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the 24-bit bitmap to RGBA stream decoder.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import bmp24rgba_pkg::*;

	localparam int QUIET_LIMIT = 1000;
	localparam int RANDOM_BYTES = 1000;

	// Results typed in for the directed rows that can be read off directly
	localparam result_t UNTYPED   = '0;
	localparam result_t SIG_FAULT = '{KIND_BAD_SIG, 24'd0, 8'd0, 8'd0, 8'd0, 8'd0,
		13'd0, 13'd0, 1'b0};
	localparam result_t HDR_FAULT = '{KIND_BAD_HEADER, 24'd0, 8'd0, 8'd0, 8'd0, 8'd0,
		13'd0, 13'd0, 1'b0};
	localparam result_t BLACK_1X1 = '{KIND_PIXEL, 24'd0, 8'd0, 8'd0, 8'd0, 8'd0,
		13'd1, 13'd1, 1'b1};

	typedef enum logic [1:0] {
		SCAN_HEADER,
		SCAN_SKIP,
		SCAN_PIXELS,
		SCAN_DONE
	} scan_phase_t;

	// Description of one bitmap file to be streamed
	typedef struct {
		logic [7:0]  sig_b;
		logic [7:0]  sig_m;
		logic [31:0] offset;
		logic [31:0] width;
		logic [31:0] height;
		int          cut;
		int          tail;
		int          key_pct;
		logic        first_start;
		bit          typed;
		result_t     typed_res;
	} file_row_t;

	// Directed files: signature, offset, width, height, cut, tail, keyed %, start, typed
	file_row_t directed_files[19] = '{
		'{SIG_B, SIG_M, 32'd26, 32'd1, 32'd1, 0, 0, 100, 1'b0, 1'b1, BLACK_1X1},
		'{SIG_B, 8'h58, 32'd26, 32'd4, 32'd4, 0, 5, 0, 1'b1, 1'b1, SIG_FAULT},
		'{SIG_M, SIG_B, 32'd26, 32'd4, 32'd4, 0, 5, 0, 1'b1, 1'b1, SIG_FAULT},
		'{SIG_B, SIG_M, 32'd25, 32'd2, 32'd2, 0, 4, 0, 1'b1, 1'b1, HDR_FAULT},
		'{SIG_B, SIG_M, 32'd0, 32'd2, 32'd2, 0, 4, 0, 1'b1, 1'b1, HDR_FAULT},
		'{SIG_B, SIG_M, 32'd26, 32'd0, 32'd2, 0, 4, 0, 1'b1, 1'b1, HDR_FAULT},
		'{SIG_B, SIG_M, 32'd26, 32'd4097, 32'd2, 0, 4, 0, 1'b1, 1'b1, HDR_FAULT},
		'{SIG_B, SIG_M, 32'd26, 32'hffff_ffff, 32'd2, 0, 4, 0, 1'b1, 1'b1, HDR_FAULT},
		'{SIG_B, SIG_M, 32'd26, 32'd2, 32'd0, 0, 4, 0, 1'b1, 1'b1, HDR_FAULT},
		'{SIG_B, SIG_M, 32'd26, 32'd2, 32'd4097, 0, 4, 0, 1'b1, 1'b1, HDR_FAULT},
		'{SIG_B, SIG_M, 32'd26, 32'd2, 32'hffff_ffff, 0, 4, 0, 1'b1, 1'b1, HDR_FAULT},
		'{SIG_B, SIG_M, 32'd26, 32'd1, 32'd3, 0, 0, 30, 1'b1, 1'b0, UNTYPED},
		'{SIG_B, SIG_M, 32'd40, 32'd2, 32'd2, 0, 6, 30, 1'b1, 1'b0, UNTYPED},
		'{SIG_B, SIG_M, 32'd26, 32'd3, 32'd2, 0, 0, 30, 1'b1, 1'b0, UNTYPED},
		'{SIG_B, SIG_M, 32'd26, 32'd4, 32'd1, 0, 3, 30, 1'b1, 1'b0, UNTYPED},
		'{SIG_B, SIG_M, 32'd26, 32'd4096, 32'd1, 60, 0, 5, 1'b1, 1'b0, UNTYPED},
		'{SIG_B, SIG_M, 32'd26, 32'd1, 32'd4096, 60, 0, 5, 1'b1, 1'b0, UNTYPED},
		'{SIG_B, SIG_M, 32'd26, 32'd3, 32'd3, 40, 0, 30, 1'b1, 1'b0, UNTYPED},
		'{SIG_B, SIG_M, 32'hffff_ffff, 32'd2, 32'd2, 40, 0, 0, 1'b1, 1'b0, UNTYPED}
	};

	logic    clk;
	logic    arst_n = 1'b0;
	logic    cfg_write_en = 1'b0;
	logic [23:0] cfg_write_data = '0;
	logic    byte_valid = 1'b0;
	logic    byte_stall;
	in_item_t byte_data = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result_data;

	// Expected decoder results, oldest first
	result_t awaited_results[$];
	int fails = 0;

	// Idling controls
	bit calm = 1'b0;
	int send_idle_pct = 10;
	int stall_pct = 10;
	int stall_left = 0;

	// Decoder state as seen by the predictor
	scan_phase_t scan;
	logic [31:0] byte_pos;
	logic [31:0] hdr_word;
	logic [31:0] data_offset;
	logic [12:0] img_w;
	logic [12:0] img_h;
	logic [15:0] pair;
	logic [1:0]  pix_byte;
	logic [12:0] col;
	logic [12:0] row;
	logic [1:0]  pad_left;
	logic [23:0] dst;
	logic [23:0] colour_key;

	bmp24_stream_to_rgba uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write_en  (cfg_write_en),
		.cfg_write_data(cfg_write_data),
		.byte_valid    (byte_valid),
		.byte_stall    (byte_stall),
		.byte_data     (byte_data),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.result_data   (result_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Return the parse to the start of a new file.
	task automatic clear_scan();
		scan = SCAN_HEADER;
		byte_pos = '0;
		hdr_word = '0;
		data_offset = '0;
		img_w = '0;
		img_h = '0;
		pair = '0;
		pix_byte = '0;
		col = '0;
		row = '0;
		pad_left = '0;
		dst = '0;
	endtask

	// Work out what one file byte does to the decoder, and any result it yields.
	task automatic decode_byte(input logic [7:0] b, input logic s, output logic got,
			output result_t r);
		logic [23:0] colour;
		bit faulted;
		result_kind_t fault;
		got = 1'b0;
		r = '0;
		faulted = 1'b0;
		fault = KIND_BAD_HEADER;
		if (s) clear_scan();
		if (scan == SCAN_HEADER) begin
			// Header words arrive little-endian, so shift in from the top.
			hdr_word = {b, hdr_word[31:8]};
			if (byte_pos == POS_SIG_LAST && hdr_word[31:16] != {SIG_M, SIG_B}) begin
				faulted = 1'b1;
				fault = KIND_BAD_SIG;
			end else if (byte_pos == POS_OFFSET_LAST) begin
				data_offset = hdr_word;
				faulted = data_offset < HEADER_END;
			end else if (byte_pos == POS_WIDTH_LAST) begin
				faulted = hdr_word == 0 || hdr_word > DEF_MAX_WIDTH;
				if (!faulted) img_w = 13'(hdr_word);
			end else if (byte_pos == POS_HEIGHT_LAST) begin
				faulted = hdr_word == 0 || hdr_word > DEF_MAX_HEIGHT;
				if (!faulted) begin
					img_h = 13'(hdr_word);
					dst = 24'(32'(img_w) * (32'(img_h) - 32'd1));
					col = '0;
					row = '0;
					pix_byte = '0;
					pad_left = '0;
					scan = SCAN_SKIP;
				end
			end
			if (faulted) begin
				got = 1'b1;
				r.result_kind = fault;
				scan = SCAN_DONE;
			end
		end else begin
			if (scan == SCAN_SKIP && byte_pos >= data_offset) scan = SCAN_PIXELS;
			if (scan == SCAN_PIXELS) begin
				if (pad_left != 0) begin
					pad_left--;
				end else if (pix_byte < 2) begin
					if (pix_byte == 0) pair = {8'h00, b};
					else pair[15:8] = b;
					pix_byte++;
				end else begin
					// Third byte completes the pixel: blue, green, then red.
					pix_byte = '0;
					colour = {b, pair};
					got = 1'b1;
					r.result_kind = KIND_PIXEL;
					r.pixel_index = dst;
					if (colour != colour_key) begin
						r.out_red = colour[23:16];
						r.out_green = colour[15:8];
						r.out_blue = colour[7:0];
						r.out_alpha = ALPHA_OPAQUE;
					end
					r.image_width = img_w;
					r.image_height = img_h;
					col++;
					if (col >= img_w) begin
						// End of row: skip padding and step to the row above.
						col = '0;
						row++;
						pad_left = 2'(32'd4 - ((32'd3 * 32'(img_w)) & 32'd3));
						if (row >= img_h) begin
							r.last_pixel = 1'b1;
							scan = SCAN_DONE;
						end else begin
							dst = dst + 24'd1 - 24'(32'd2 * 32'(img_w));
						end
					end else begin
						dst++;
					end
				end
			end
		end
		if (byte_pos != '1) byte_pos++;
	endtask

	// Offer one byte transaction, wait for acceptance and record what it yields.
	task automatic put_byte(input logic [7:0] b, input logic s, input bit typed,
			input result_t typed_res);
		result_t r;
		logic got;
		if (!calm && $urandom_range(99) < send_idle_pct) begin
			byte_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_data <= '{file_byte: b, file_start: s};
		do @(posedge clk); while (byte_stall);
		decode_byte(b, s, got, r);
		if (got) awaited_results.push_back(typed ? typed_res : r);
	endtask

	// Build a file image from its description and stream it.
	task automatic send_file(input file_row_t f, output int counted);
		logic [7:0] img[$];
		logic [31:0] limit;
		logic [23:0] px;
		logic [1:0] pad;
		int body;
		limit = f.cut > 0 ? 32'(f.cut) : 32'h7fff_ffff;
		for (int i = 0; i < 26; i++) img.push_back(8'($urandom));
		img[0] = f.sig_b;
		img[1] = f.sig_m;
		for (int i = 0; i < 4; i++) begin
			img[10 + i] = f.offset[8 * i +: 8];
			img[18 + i] = f.width[8 * i +: 8];
			img[22 + i] = f.height[8 * i +: 8];
		end
		while (img.size() < f.offset && img.size() < limit) img.push_back(8'($urandom));
		// Pixel data only follows a header that the decoder accepts.
		if ({f.sig_m, f.sig_b} == {SIG_M, SIG_B} && f.offset >= HEADER_END
				&& f.offset < 32'h1_0000 && f.width != 0 && f.width <= DEF_MAX_WIDTH
				&& f.height != 0 && f.height <= DEF_MAX_HEIGHT) begin
			pad = 2'(32'd4 - ((32'd3 * f.width) & 32'd3));
			for (int y = 0; y < f.height; y++) begin
				for (int x = 0; x < f.width; x++) begin
					px = ($urandom_range(99) < f.key_pct) ? colour_key : 24'($urandom);
					img.push_back(px[7:0]);
					img.push_back(px[15:8]);
					img.push_back(px[23:16]);
				end
				repeat (pad) img.push_back(8'($urandom));
			end
		end
		body = img.size();
		repeat (f.tail) img.push_back(8'($urandom));
		while (img.size() > limit) void'(img.pop_back());
		counted = img.size() < body ? img.size() : body;
		foreach (img[i]) put_byte(img[i], i == 0 ? f.first_start : 1'b0, f.typed, f.typed_res);
	endtask

	// Hold the sender until every expected result is in, then let the pipe empty.
	task automatic drain_results();
		byte_valid <= 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write the colour key while the decoder is idle.
	task automatic load_colour_key(input logic [23:0] k);
		drain_results();
		cfg_write_en <= 1'b1;
		cfg_write_data <= k;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		colour_key = k;
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fails++;
		end
	endtask

	// Receiver stalls in random bursts.
	always @(posedge clk) begin
		if (calm) begin
			result_stall <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else if ($urandom_range(99) < stall_pct) begin
			result_stall <= 1'b1;
			stall_left <= $urandom_range(0, 14);
		end else begin
			result_stall <= 1'b0;
		end
	end

	// Compare each accepted result transaction with the oldest expectation.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (awaited_results.size() == 0) begin
				$error("unexpected result of kind %0d", result_data.result_kind);
				fails++;
			end else begin
				want = awaited_results.pop_front();
				check_field("result_kind", 32'(want.result_kind),
					32'(result_data.result_kind));
				check_field("pixel_index", 32'(want.pixel_index),
					32'(result_data.pixel_index));
				check_field("out_red", 32'(want.out_red), 32'(result_data.out_red));
				check_field("out_green", 32'(want.out_green), 32'(result_data.out_green));
				check_field("out_blue", 32'(want.out_blue), 32'(result_data.out_blue));
				check_field("out_alpha", 32'(want.out_alpha), 32'(result_data.out_alpha));
				check_field("image_width", 32'(want.image_width),
					32'(result_data.image_width));
				check_field("image_height", 32'(want.image_height),
					32'(result_data.image_height));
				check_field("last_pixel", 32'(want.last_pixel),
					32'(result_data.last_pixel));
			end
		end
	end

	// Watchdog: too long without any transaction on either side ends the run.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (byte_valid && !byte_stall) || (result_valid && !result_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("TEST FAILED");
		$finish;
	end

	// Main sequence: reset, directed files, then random files over four key settings.
	initial begin
		file_row_t f;
		logic [23:0] keys[4];
		int counted;
		int total;
		int pick;
		clear_scan();
		colour_key = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_files[i]) send_file(directed_files[i], counted);

		keys[0] = 24'hff_ffff;
		keys[1] = 24'($urandom);
		keys[2] = 24'($urandom);
		keys[3] = 24'h00_0000;
		for (int ph = 0; ph < 4; ph++) begin
			load_colour_key(keys[ph]);
			calm = ph == 3;
			total = 0;
			while (total < RANDOM_BYTES / 4) begin
				send_idle_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(2, 25);
				stall_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(2, 25);
				if (!calm && $urandom_range(29) == 0) drain_results();

				// Mostly well-formed small files with random content.
				f.sig_b = SIG_B;
				f.sig_m = SIG_M;
				f.offset = 32'd26 + (($urandom_range(9) == 0) ? $urandom_range(0, 60)
					: $urandom_range(0, 6));
				f.width = ($urandom_range(9) == 0) ? $urandom_range(1, 40)
					: $urandom_range(1, 8);
				f.height = ($urandom_range(9) == 0) ? $urandom_range(1, 12)
					: $urandom_range(1, 4);
				f.cut = 0;
				f.tail = $urandom_range(0, 4);
				f.key_pct = $urandom_range(0, 40);
				f.first_start = 1'b1;
				f.typed = 1'b0;
				f.typed_res = UNTYPED;

				// The rest are truncated files, broken headers and line noise.
				pick = $urandom_range(99);
				if (pick < 10) begin
					f.cut = $urandom_range(2, 90);
				end else if (pick < 14) begin
					f.offset = $urandom_range(0, 25);
				end else if (pick < 18) begin
					f.width = $urandom;
					if (f.width <= DEF_MAX_WIDTH) f.width = '0;
				end else if (pick < 22) begin
					f.height = $urandom;
					if (f.height <= DEF_MAX_HEIGHT) f.height = '0;
				end else if (pick < 27) begin
					f.sig_b = 8'($urandom);
					f.sig_m = 8'($urandom);
					if ({f.sig_b, f.sig_m} == {SIG_B, SIG_M}) f.sig_m = ~SIG_M;
				end

				if (pick >= 27 && pick < 32) begin
					repeat ($urandom_range(1, 20))
						put_byte(8'($urandom), $urandom_range(7) == 0, 1'b0, UNTYPED);
				end else begin
					send_file(f, counted);
					total += counted;
				end
			end
		end

		drain_results();
		repeat (4) @(posedge clk);
		if (fails == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
